[rtl/shs_pkg.sv]
// Shared types, command and status structs, and SHA-256 constants for the stream hasher.
`timescale 1ns / 1ps

package shs_pkg;

    localparam int RoundCount = 64;
    localparam int HashWords  = 8;
    localparam int SchedWords = 16;

    localparam logic [5:0] LastRound = 6'(RoundCount - 1);
    localparam logic [5:0] LastFill  = 6'd63;
    localparam logic [5:0] LenStart  = 6'd56;
    localparam logic [2:0] LastWord  = 3'(HashWords - 1);
    localparam logic [7:0] PadByte   = 8'h80;

    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN
    } t_byte_src;

    typedef struct packed {
        logic      push;
        t_byte_src src;
        logic      load_work;
        logic      round;
        logic [5:0] round_idx;
        logic      add_hash;
        logic      restart;
        logic [2:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
    } t_status;

    localparam logic [31:0] RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

[rtl/shs_datapath.sv]
// Datapath: block shift line, message schedule, round logic, hash words and bit count.
`timescale 1ns / 1ps

module shs_datapath
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_status     o_status,
    output logic [31:0] o_digest_word
);

    logic [31:0] r_hash [HashWords];
    logic [31:0] r_work [HashWords];
    logic [31:0] r_sched [SchedWords];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;

    logic [7:0]  push_byte;
    logic [7:0]  len_byte;
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] temp1;
    logic [31:0] temp2;
    logic [31:0] n_w16;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // The length goes out most significant byte first, starting at fill 56.
    assign len_byte = 8'(r_bits >> {~r_fill[2:0], 3'b000});

    always_comb begin
        case (i_cmd.src)
            SRC_MSG:   push_byte = i_data_byte;
            SRC_PAD80: push_byte = PadByte;
            SRC_ZERO:  push_byte = 8'h00;
            SRC_LEN:   push_byte = len_byte;
            default:   push_byte = 8'h00;
        endcase
    end

    always_comb begin
        big1   = rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25);
        choose = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        temp1  = r_work[7] + big1 + choose + RoundK[i_cmd.round_idx] + r_sched[0];
        big0   = rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22);
        major  = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
        temp2  = big0 + major;
        n_w16  = r_sched[0] + small_sig0(r_sched[1]) + r_sched[9] + small_sig1(r_sched[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HashWords; i++) begin
                r_hash[i] <= InitHash[i];
            end
            r_fill <= '0;
            r_bits <= '0;
        end else if (i_cmd.restart) begin
            for (int i = 0; i < HashWords; i++) begin
                r_hash[i] <= InitHash[i];
            end
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.push && i_cmd.src == SRC_MSG) begin
                r_bits <= r_bits + 64'd8;
            end
            if (i_cmd.add_hash) begin
                for (int i = 0; i < HashWords; i++) begin
                    r_hash[i] <= r_hash[i] + r_work[i];
                end
            end
        end
    end

    // Bytes shift in at the tail of the line; each round takes word 0 and appends W[t+16].
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                r_sched[i] <= {r_sched[i][23:0], r_sched[i + 1][31:24]};
            end
            r_sched[SchedWords - 1] <= {r_sched[SchedWords - 1][23:0], push_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                r_sched[i] <= r_sched[i + 1];
            end
            r_sched[SchedWords - 1] <= n_w16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_work) begin
            for (int i = 0; i < HashWords; i++) begin
                r_work[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_work[0] <= temp1 + temp2;
            r_work[1] <= r_work[0];
            r_work[2] <= r_work[1];
            r_work[3] <= r_work[2];
            r_work[4] <= r_work[3] + temp1;
            r_work[5] <= r_work[4];
            r_work[6] <= r_work[5];
            r_work[7] <= r_work[6];
        end
    end

    assign o_status      = {(r_fill == LastFill), (r_fill == LenStart)};
    assign o_digest_word = r_hash[i_cmd.word_idx];

endmodule

[rtl/shs_ctrl.sv]
// Controller: sequences byte loads, padding, compression rounds and digest output.
`timescale 1ns / 1ps

module shs_ctrl
    import shs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_has_byte,
    input  logic       i_end_of_message,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MSG,
        PH_ZERO,
        PH_DONE
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic       r_fin, n_fin;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_round     = r_round;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd           = '0;
        o_cmd.src       = SRC_MSG;
        o_cmd.round_idx = r_round;
        o_cmd.word_idx  = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.push = i_has_byte;
                    n_fin      = i_end_of_message;
                    n_phase    = PH_MSG;
                    if (i_has_byte && i_status.fill_last) begin
                        o_cmd.load_work = 1'b1;
                        n_round         = '0;
                        n_state         = ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_PAD80;
                n_phase    = PH_ZERO;
                if (i_status.fill_last) begin
                    o_cmd.load_work = 1'b1;
                    n_round         = '0;
                    n_state         = ST_ROUND;
                end else begin
                    n_state = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (i_status.fill_at_len) begin
                    n_state = ST_PADLEN;
                end else begin
                    o_cmd.push = 1'b1;
                    o_cmd.src  = SRC_ZERO;
                    if (i_status.fill_last) begin
                        o_cmd.load_work = 1'b1;
                        n_round         = '0;
                        n_state         = ST_ROUND;
                    end
                end
            end
            ST_PADLEN: begin
                o_cmd.push = 1'b1;
                o_cmd.src  = SRC_LEN;
                if (i_status.fill_last) begin
                    o_cmd.load_work = 1'b1;
                    n_round         = '0;
                    n_phase         = PH_DONE;
                    n_state         = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 6'd1;
                if (r_round == LastRound) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.add_hash = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else begin
                    case (r_phase)
                        PH_MSG:  n_state = ST_PAD80;
                        PH_ZERO: n_state = ST_PADZ;
                        PH_DONE: begin
                            n_out_valid = 1'b1;
                            n_idx       = '0;
                            n_state     = ST_OUT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_idx == LastWord) begin
                        o_cmd.restart = 1'b1;
                        n_out_valid   = 1'b0;
                        n_fin         = 1'b0;
                        n_phase       = PH_MSG;
                        n_state       = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_MSG;
            r_fin       <= 1'b0;
            r_round     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fin       <= n_fin;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LastWord);

endmodule

[rtl/sha256_stream_hasher_top.sv]
// Top level of the SHA-256 stream hasher: controller plus datapath.
`timescale 1ns / 1ps
// The input channel takes one beat per item: an optional message byte and an end mark.
// A beat with the end mark and no byte closes the message with the bytes already taken.
// The output channel returns the eight digest words, index 0 first, with last_word on
// word 7, once per finished message.
// A byte that does not complete a 64-byte block is taken without a stall, and the block
// accepts a beat on every cycle while it is waiting for input.
// A byte that completes a block starts a compression: 64 rounds through one shared
// round unit, then the hash update, and then a return to idle unless the message
// has ended.
// At the end mark padding bytes (up to 64) go in one per cycle between compressions;
// a step without a push then switches to the length, and one or two compressions run;
// the first digest word appears the cycle after the final hash update.
// No input beat is taken while padding, compressing or sending the digest.
// If the receiver stalls, the current word stays on the output and the block waits.
// Synchronous reset loads the initial hash values and clears the byte and bit counts.
// After the last digest word is taken, the block is ready for the next message.

module sha256_stream_hasher_top
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_cmd    cmd;
    t_status status;

    shs_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_in_ready       (o_in_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    shs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .o_status      (status),
        .o_digest_word (o_digest_word)
    );

endmodule

[rtl/shs_checker.sv]
// Port-level checker for the stream hasher and its bind to the top level.
`timescale 1ns / 1ps

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    a_no_input_while_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("Input beat could be taken while a digest is being sent.");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_digest_word)
            && $stable(o_word_index))
        else $error("Stalled digest beat changed.");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
            o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("Digest words did not follow in order.");

    a_last_marks_word7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("Last word flag does not match word index.");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_word_index == 3'd0))
        else $error("Digest did not start at word 0.");

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
